// ===== rtl/brb_pkg.sv =====
// brb_pkg: shared widths, operation and result codes, and command/result types
// for the byte ring buffer; used by brb_front, brb_back and byte_ring_buffer_top
`default_nettype none

package brb_pkg;

    localparam int OP_W   = 2;
    localparam int CNT_W  = 9;
    localparam int DATA_W = 8;

    // operation codes on the input word
    localparam logic [OP_W-1:0] OP_SAVE    = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

    // result kinds on the output word
    localparam logic [OP_W-1:0] KIND_SAVE    = 2'd0;
    localparam logic [OP_W-1:0] KIND_PEEK    = 2'd1;
    localparam logic [OP_W-1:0] KIND_DISCARD = 2'd2;

    // entries of the command queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0]  kind;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             last;
        logic             from_mem;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/brb_front.sv =====
// brb_front: accepts input words, drops unused operation codes and queues
// the rest as commands for the back end; depends on brb_pkg
`default_nettype none

module brb_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [brb_pkg::OP_W-1:0]  i_operation,
    input  wire logic [brb_pkg::CNT_W-1:0] i_length,
    input  wire logic [brb_pkg::DATA_W-1:0] i_data_in,
    input  wire logic                      i_burst_last,
    output logic                           o_cmd_valid,
    output brb_pkg::t_cmd                  o_cmd,
    input  wire logic                      i_cmd_pop
);

    localparam int QP_W = (brb_pkg::Q_DEPTH > 1) ? $clog2(brb_pkg::Q_DEPTH) : 1;
    localparam int QC_W = $clog2(brb_pkg::Q_DEPTH + 1);

    brb_pkg::t_cmd r_q [brb_pkg::Q_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;

    logic op_known;
    logic push;
    logic pop;
    brb_pkg::t_cmd cmd_in;

    function automatic logic [QP_W-1:0] f_qnext(input logic [QP_W-1:0] p);
        f_qnext = (p == QP_W'(brb_pkg::Q_DEPTH - 1)) ? '0 : p + QP_W'(1);
    endfunction

    // classify: unused codes are taken and dropped
    assign op_known = (i_operation == brb_pkg::OP_SAVE) ||
                      (i_operation == brb_pkg::OP_PEEK) ||
                      (i_operation == brb_pkg::OP_DISCARD);

    assign o_ready     = (r_cnt != QC_W'(brb_pkg::Q_DEPTH));
    assign push        = i_valid && o_ready && op_known;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.op   = i_operation;
        cmd_in.len  = i_length;
        cmd_in.data = i_data_in;
        cmd_in.last = i_burst_last;
        n_wp  = push ? f_qnext(r_wp) : r_wp;
        n_rp  = pop ? f_qnext(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brb_back.sv =====
// brb_back: executes queued commands against the ring store and pointers,
// streams peek bytes and holds the output register; depends on brb_pkg
`default_nettype none

module brb_back #(
    parameter int DEPTH    = 256,
    parameter int MAX_PEEK = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [brb_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_cmd_valid,
    input  wire brb_pkg::t_cmd              i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [brb_pkg::OP_W-1:0]        o_kind,
    output logic [brb_pkg::DATA_W-1:0]      o_data_out,
    output logic [brb_pkg::CNT_W-1:0]       o_count,
    output logic                            o_is_empty,
    output logic                            o_last
);

    localparam int CW      = brb_pkg::CNT_W;
    localparam int CAP_MAX = (DEPTH < 511) ? DEPTH : 511;
    localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;
    localparam int IDX_W   = $clog2(CAP_MAX);
    localparam int PK_W    = $clog2(MAX_PEEK + 1);

    logic [brb_pkg::DATA_W-1:0] r_mem [CAP_MAX];

    logic [CW-1:0]    r_cap, n_cap;
    logic [CW-1:0]    r_free, n_free;
    logic [IDX_W-1:0] r_ri, n_ri;
    logic [IDX_W-1:0] r_wi, n_wi;
    logic             r_bact, n_bact;
    logic             r_bacc, n_bacc;
    logic             r_pk_act, n_pk_act;
    logic [IDX_W-1:0] r_pk_idx, n_pk_idx;
    logic [PK_W-1:0]  r_pk_rem, n_pk_rem;
    logic [PK_W-1:0]  r_pk_n, n_pk_n;
    logic             r_s1_vld, n_s1_vld;
    brb_pkg::t_res    r_s1, n_s1;
    logic [brb_pkg::DATA_W-1:0] r_rd_data;
    logic             r_o_vld;
    brb_pkg::t_res    r_o;
    logic [brb_pkg::DATA_W-1:0] r_o_data;

    logic          s1_go;
    logic          adv;
    logic          mem_we;
    logic          rd_en;
    logic [CW-1:0] stored;
    logic [CW-1:0] cap_wr;
    logic          sv_acc;
    logic          sv_wr;
    logic [CW-1:0] sv_free;
    logic [CW-1:0] lim_n;
    logic [CW-1:0] pk_n;
    logic [CW:0]   dc_sum;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [CW:0] nx;
        nx = (CW+1)'(idx) + (CW+1)'(1);
        f_next = (nx >= (CW+1)'(cap)) ? '0 : IDX_W'(nx);
    endfunction

    assign s1_go  = r_s1_vld && (!r_o_vld || i_ready);
    assign adv    = !r_s1_vld || s1_go;
    assign stored = r_cap - r_free;

    // clamp the written capacity to 1..CAP_MAX
    always_comb begin
        cap_wr = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cap_wr = CW'(1);
        end else if (i_cfg_wdata > CW'(CAP_MAX)) begin
            cap_wr = CW'(CAP_MAX);
        end
    end

    // save: acceptance decided on the first byte of a burst
    assign sv_acc  = r_bact ? r_bacc : ((i_cmd.len != '0) && (i_cmd.len <= r_free));
    assign sv_wr   = sv_acc && (r_free != '0);
    assign sv_free = sv_wr ? (r_free - CW'(1)) : r_free;

    assign lim_n  = (i_cmd.len > stored) ? stored : i_cmd.len;
    assign pk_n   = (lim_n > CW'(MAX_PEEK)) ? CW'(MAX_PEEK) : lim_n;
    assign dc_sum = (CW+1)'(r_ri) + (CW+1)'(lim_n);

    always_comb begin
        n_cap     = r_cap;
        n_free    = r_free;
        n_ri      = r_ri;
        n_wi      = r_wi;
        n_bact    = r_bact;
        n_bacc    = r_bacc;
        n_pk_act  = r_pk_act;
        n_pk_idx  = r_pk_idx;
        n_pk_rem  = r_pk_rem;
        n_pk_n    = r_pk_n;
        n_s1_vld  = r_s1_vld && !s1_go;
        n_s1      = r_s1;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        o_cmd_pop = 1'b0;
        if (i_cfg_we) begin
            n_cap    = cap_wr;
            n_free   = cap_wr;
            n_ri     = '0;
            n_wi     = '0;
            n_bact   = 1'b0;
            n_bacc   = 1'b0;
            n_pk_act = 1'b0;
        end else if (adv) begin
            if (r_pk_act) begin
                // one peek byte a cycle while the result stage can advance
                rd_en          = 1'b1;
                n_s1_vld       = 1'b1;
                n_s1.kind      = brb_pkg::KIND_PEEK;
                n_s1.count     = CW'(r_pk_n);
                n_s1.is_empty  = (r_free == r_cap);
                n_s1.last      = (r_pk_rem == PK_W'(1));
                n_s1.from_mem  = 1'b1;
                n_pk_idx       = f_next(r_pk_idx, r_cap);
                n_pk_rem       = r_pk_rem - PK_W'(1);
                if (r_pk_rem == PK_W'(1)) begin
                    n_pk_act = 1'b0;
                end
            end else if (i_cmd_valid) begin
                o_cmd_pop = 1'b1;
                case (i_cmd.op)
                    brb_pkg::OP_SAVE: begin
                        if (sv_wr) begin
                            mem_we = 1'b1;
                            n_wi   = f_next(r_wi, r_cap);
                            n_free = sv_free;
                        end
                        if (i_cmd.last) begin
                            n_bact        = 1'b0;
                            n_bacc        = 1'b0;
                            n_s1_vld      = 1'b1;
                            n_s1.kind     = brb_pkg::KIND_SAVE;
                            n_s1.count    = sv_acc ? i_cmd.len : '0;
                            n_s1.is_empty = (sv_free == r_cap);
                            n_s1.last     = 1'b1;
                            n_s1.from_mem = 1'b0;
                        end else begin
                            n_bact = 1'b1;
                            n_bacc = sv_acc;
                        end
                    end
                    brb_pkg::OP_PEEK: begin
                        if (pk_n == '0) begin
                            n_s1_vld      = 1'b1;
                            n_s1.kind     = brb_pkg::KIND_PEEK;
                            n_s1.count    = '0;
                            n_s1.is_empty = (r_free == r_cap);
                            n_s1.last     = 1'b1;
                            n_s1.from_mem = 1'b0;
                        end else begin
                            n_pk_act = 1'b1;
                            n_pk_idx = r_ri;
                            n_pk_rem = PK_W'(pk_n);
                            n_pk_n   = PK_W'(pk_n);
                        end
                    end
                    brb_pkg::OP_DISCARD: begin
                        n_ri = (dc_sum >= (CW+1)'(r_cap)) ?
                               IDX_W'(dc_sum - (CW+1)'(r_cap)) : IDX_W'(dc_sum);
                        n_free        = r_free + lim_n;
                        n_s1_vld      = 1'b1;
                        n_s1.kind     = brb_pkg::KIND_DISCARD;
                        n_s1.count    = lim_n;
                        n_s1.is_empty = ((r_free + lim_n) == r_cap);
                        n_s1.last     = 1'b1;
                        n_s1.from_mem = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CW'(CAP_RST);
            r_free   <= CW'(CAP_RST);
            r_ri     <= '0;
            r_wi     <= '0;
            r_bact   <= 1'b0;
            r_bacc   <= 1'b0;
            r_pk_act <= 1'b0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_cap    <= n_cap;
            r_free   <= n_free;
            r_ri     <= n_ri;
            r_wi     <= n_wi;
            r_bact   <= n_bact;
            r_bacc   <= n_bacc;
            r_pk_act <= n_pk_act;
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= s1_go || (r_o_vld && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pk_idx <= n_pk_idx;
        r_pk_rem <= n_pk_rem;
        r_pk_n   <= n_pk_n;
        r_s1     <= n_s1;
        if (s1_go) begin
            r_o      <= r_s1;
            r_o_data <= r_s1.from_mem ? r_rd_data : '0;
        end
    end

    // ring store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wi] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_pk_idx];
        end
    end

    assign o_valid    = r_o_vld;
    assign o_kind     = r_o.kind;
    assign o_data_out = r_o_data;
    assign o_count    = r_o.count;
    assign o_is_empty = r_o.is_empty;
    assign o_last     = r_o.last;

endmodule

`default_nettype wire

// ===== rtl/byte_ring_buffer_top.sv =====
// byte_ring_buffer_top: circular byte store with save, peek and discard
// depends on brb_pkg, brb_front and brb_back
//
// channel   handshake           fields
// input     i_valid / o_ready   i_operation i_length i_data_in i_burst_last
// output    o_valid / i_ready   o_kind o_data_out o_count o_is_empty o_last
// config    i_cfg_we            i_cfg_wdata (capacity)
//
// save and discard words are each done as the back end pops them, so save bursts stream at
// one byte a cycle while the output side does not stall; peek bytes come from the single
// read port of the store, one byte a cycle under the same condition. results pass through
// the command queue, the result stage and the output register; peek bytes also the store read.
// reset (synchronous) empties the buffer and sets capacity to min(DEPTH, 256).
// a 2-word command queue sits between front and back, and a result stage plus output
// register let the back work on while the output side stalls, until the result stage is full.
`default_nettype none

module byte_ring_buffer_top #(
    parameter int DEPTH    = 256,
    parameter int MAX_PEEK = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [brb_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [brb_pkg::OP_W-1:0]    i_operation,
    input  wire logic [brb_pkg::CNT_W-1:0]   i_length,
    input  wire logic [brb_pkg::DATA_W-1:0]  i_data_in,
    input  wire logic                        i_burst_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [brb_pkg::OP_W-1:0]         o_kind,
    output logic [brb_pkg::DATA_W-1:0]       o_data_out,
    output logic [brb_pkg::CNT_W-1:0]        o_count,
    output logic                             o_is_empty,
    output logic                             o_last
);

    logic          cmd_valid;
    brb_pkg::t_cmd cmd;
    logic          cmd_pop;

    brb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_length     (i_length),
        .i_data_in    (i_data_in),
        .i_burst_last (i_burst_last),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    brb_back #(
        .DEPTH    (DEPTH),
        .MAX_PEEK (MAX_PEEK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data_out  (o_data_out),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
